FILE: sv/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the discrete energy sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package des_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 256;
  localparam int unsigned ENERGY_W        = 32;
  localparam int unsigned WEIGHT_W        = 23;
  localparam int unsigned FRAC_W          = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_e;

  typedef struct packed {
    func_e               func;
    logic [ENERGY_W-1:0] line_energy;
    logic [WEIGHT_W-1:0] line_intensity;
    logic [FRAC_W-1:0]   uniform_fraction;
  } in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] sampled_energy;
    logic                found;
  } out_t;

  // One table entry as held in the line store
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [WEIGHT_W-1:0] weight;
  } line_t;

endpackage

`default_nettype wire

FILE: sv/des_store.sv
// ----------------------------------------------------------------------------
// des_store
// Line table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module des_store #(
  parameter int unsigned MaxEntries = des_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MaxEntries)-1:0] wr_addr_i,
  input  des_pkg::line_t                wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MaxEntries)-1:0] rd_addr_i,
  output des_pkg::line_t                rd_data_o
);
  import des_pkg::*;

  line_t mem_q [MaxEntries];
  line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/des_thresh.sv
// ----------------------------------------------------------------------------
// des_thresh
// Sample threshold: floor(u * total / 2^32), registered.
// ----------------------------------------------------------------------------
`default_nettype none

module des_thresh #(
  parameter int unsigned MaxEntries = des_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                                   clk_i,
  input  logic                                                   en_i,
  input  logic [des_pkg::FRAC_W-1:0]                             frac_i,
  input  logic [des_pkg::WEIGHT_W+$clog2(MaxEntries)-1:0]        total_i,
  output logic [des_pkg::WEIGHT_W+$clog2(MaxEntries)-1:0]        thresh_o
);
  import des_pkg::*;

  localparam int unsigned TotW  = WEIGHT_W + $clog2(MaxEntries);
  localparam int unsigned ProdW = FRAC_W + TotW;

  logic [ProdW-1:0] prod;
  logic [TotW-1:0]  thresh_q;

  assign prod = ProdW'(frac_i) * ProdW'(total_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      thresh_q <= prod[FRAC_W +: TotW];
    end
  end

  assign thresh_o = thresh_q;

endmodule

`default_nettype wire

FILE: sv/discrete_energy_sampler.sv
// ----------------------------------------------------------------------------
// discrete_energy_sampler
// Sorted table of energy lines with an inverse-CDF sampler over it.
// ----------------------------------------------------------------------------
// A clear empties the table. A load walks the table from the top, moving each
// line heavier than the new one up by one place, then writes the new line into
// the gap. A sample visits entries in order until the running sum passes its
// threshold or the table ends; an empty table or zero total gives a miss
// without a walk. A sample waits while the result register is full and not
// taken. Both walks are set by the single read port of the line store, one
// entry per cycle while no such wait holds. One item is in work at a time; a
// sample returns one result transfer, clear and load none.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_energy_sampler #(
  parameter int unsigned MAX_ENTRIES = des_pkg::DEF_MAX_ENTRIES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  des_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output des_pkg::out_t out_data_o
);
  import des_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TotW = WEIGHT_W + IdxW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_EMPTY,
    ST_SAMP
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [TotW-1:0] total_q;
  logic [CntW-1:0] k_q;
  logic [TotW-1:0] sum_q;
  line_t           new_q;
  logic            out_valid_q;
  out_t            out_q;

  logic            acc;
  logic            slot_free;
  logic            out_load;
  logic            tbl_full;
  logic            tbl_empty;
  logic            ins_shift;
  logic            hit;
  logic            last;
  logic [TotW-1:0] sum_next;
  logic [TotW-1:0] thresh;
  line_t           rd_data;
  line_t           in_line;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  line_t           wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign tbl_full   = (count_q == CntW'(MAX_ENTRIES));
  assign tbl_empty  = (count_q == '0) || (total_q == '0);
  assign in_line    = '{energy: in_data_i.line_energy, weight: in_data_i.line_intensity};

  assign ins_shift  = (rd_data.weight > new_q.weight);
  assign sum_next   = sum_q + TotW'(rd_data.weight);
  assign hit        = (thresh < sum_next);
  assign last       = ((k_q + CntW'(1)) == count_q);

  // result register is reloaded this cycle
  assign out_load   = slot_free && ((state_q == ST_EMPTY) ||
                                    ((state_q == ST_SAMP) && (hit || last)));

  // store port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_data_i.func == FUNC_LOAD && !tbl_full) begin
          if (count_q == '0) begin
            wr_en   = 1'b1;
            wr_data = in_line;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(count_q - CntW'(1));
          end
        end else if (acc && in_data_i.func == FUNC_SAMPLE && !tbl_empty) begin
          rd_en = 1'b1;
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = IdxW'(k_q);
        if (ins_shift) begin
          wr_data = rd_data;
          if (k_q != CntW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(k_q - CntW'(2));
          end
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = IdxW'(k_q);
      end
      ST_SAMP: begin
        if (slot_free && !hit && !last) begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(k_q + CntW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      new_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (in_data_i.func)
              FUNC_CLEAR: begin
                count_q <= '0;
                total_q <= '0;
              end
              FUNC_LOAD: begin
                if (!tbl_full) begin
                  // totals are settled now; the walk only moves lines
                  new_q   <= in_line;
                  k_q     <= count_q;
                  count_q <= count_q + CntW'(1);
                  total_q <= total_q + TotW'(in_data_i.line_intensity);
                  if (count_q != '0) begin
                    state_q <= ST_INS;
                  end
                end
              end
              FUNC_SAMPLE: begin
                k_q   <= '0;
                sum_q <= '0;
                if (tbl_empty) begin
                  state_q <= ST_EMPTY;
                end else begin
                  state_q <= ST_SAMP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_INS: begin
          if (ins_shift) begin
            k_q <= k_q - CntW'(1);
            if (k_q == CntW'(1)) begin
              state_q <= ST_PUT;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PUT: begin
          state_q <= ST_IDLE;
        end
        ST_EMPTY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end
        ST_SAMP: begin
          if (slot_free) begin
            if (hit) begin
              out_valid_q <= 1'b1;
              out_q       <= '{sampled_energy: rd_data.energy, found: 1'b1};
              state_q     <= ST_IDLE;
            end else if (last) begin
              out_valid_q <= 1'b1;
              out_q       <= '0;
              state_q     <= ST_IDLE;
            end else begin
              k_q   <= k_q + CntW'(1);
              sum_q <= sum_next;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  des_store #(
    .MaxEntries(MAX_ENTRIES)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  des_thresh #(
    .MaxEntries(MAX_ENTRIES)
  ) u_thresh (
    .clk_i   (clk_i),
    .en_i    (acc),
    .frac_i  (in_data_i.uniform_fraction),
    .total_i (total_q),
    .thresh_o(thresh)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_samp_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SAMP |-> (count_q != '0 && total_q != '0))
    else $error("sample walk over an empty table");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("store read and write hit the same entry");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.sampled_energy == '0))
    else $error("miss result carries an energy");
`endif

endmodule

`default_nettype wire
